>>> rtl/alr_pkg.sv
`default_nettype none

package alr_pkg;

   localparam int COLOR_W = 8;
   localparam int LANES   = 3;
   localparam int QUOT_W  = 8;

   localparam logic [COLOR_W-1:0] COLOR_MAX = 8'd255;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   typedef enum logic [1:0] {
      PIX_MAIN,
      PIX_NBR,
      PIX_END
   } pix_sel_type;

   typedef struct packed {
      logic        load_line;
      logic        div_start;
      logic        out_load;
      pix_sel_type out_sel;
      logic        advance;
      logic        end_line;
   } cmd_type;

   typedef struct packed {
      logic line_active;
      logic div_done;
      logic out_free;
      logic at_stop;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/alr_if.sv
`default_nettype none

interface alr_req_if #(parameter int CW = 11);
   import alr_pkg::*;

   logic               valid;
   logic               ready;
   logic               op;
   logic [CW-1:0]      x_start;
   logic [CW-1:0]      y_start;
   logic [CW-1:0]      x_end;
   logic [CW-1:0]      y_end;
   logic [COLOR_W-1:0] red;
   logic [COLOR_W-1:0] green;
   logic [COLOR_W-1:0] blue;

   modport source (output valid, op, x_start, y_start, x_end, y_end, red, green, blue,
                   input ready);
   modport sink   (input valid, op, x_start, y_start, x_end, y_end, red, green, blue,
                   output ready);
endinterface

interface alr_rsp_if #(parameter int CW = 11);
   import alr_pkg::*;

   logic               valid;
   logic               ready;
   logic signed [CW+1:0] pixel_x;
   logic signed [CW+1:0] pixel_y;
   logic [COLOR_W-1:0] pixel_red;
   logic [COLOR_W-1:0] pixel_green;
   logic [COLOR_W-1:0] pixel_blue;
   logic               last;

   modport source (output valid, pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue, last,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue, last,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/alr_divider.sv
`default_nettype none

module alr_divider #(
   parameter int CW = 11
) (
   input  wire logic                                           clock,
   input  wire logic                                           reset,
   input  wire logic                                           start,
   input  wire logic [CW:0]                                    divisor,
   input  wire logic [alr_pkg::LANES-1:0][CW+7:0]              dividend,
   output logic                                                done,
   output logic [alr_pkg::LANES-1:0][alr_pkg::QUOT_W-1:0]      quot,
   output logic [alr_pkg::LANES-1:0]                           rem_nz
);
   import alr_pkg::*;

   localparam int PW = CW + 8;
   localparam int CNT_W = $clog2(QUOT_W);

   logic                              busy_ff, busy_in;
   logic [CNT_W-1:0]                  cnt_ff, cnt_in;
   logic [PW-1:0]                     dsh_ff, dsh_in;
   logic [LANES-1:0][PW-1:0]          rem_ff, rem_in;
   logic [LANES-1:0][QUOT_W-1:0]      quot_ff, quot_in;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dsh_in  = dsh_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dsh_in  = {divisor, {(QUOT_W-1){1'b0}}};
         rem_in  = dividend;
         quot_in = '0;
      end else if (busy_ff) begin
         for (int i = 0; i < LANES; i++) begin
            if (rem_ff[i] >= dsh_ff) begin
               rem_in[i]  = rem_ff[i] - dsh_ff;
               quot_in[i] = {quot_ff[i][QUOT_W-2:0], 1'b1};
            end else begin
               quot_in[i] = {quot_ff[i][QUOT_W-2:0], 1'b0};
            end
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(QUOT_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff  <= cnt_in;
      dsh_ff  <= dsh_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   always_comb begin
      done = !busy_ff;
      quot = quot_ff;
      for (int i = 0; i < LANES; i++) begin
         rem_nz[i] = (rem_ff[i] != '0);
      end
   end

endmodule

`default_nettype wire

>>> rtl/alr_datapath.sv
`default_nettype none

module alr_datapath #(
   parameter int CW = 11
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire alr_pkg::cmd_type              cmd,
   output alr_pkg::status_type                status,
   input  wire logic [CW-1:0]                 x_start,
   input  wire logic [CW-1:0]                 y_start,
   input  wire logic [CW-1:0]                 x_end,
   input  wire logic [CW-1:0]                 y_end,
   input  wire logic [alr_pkg::COLOR_W-1:0]   red,
   input  wire logic [alr_pkg::COLOR_W-1:0]   green,
   input  wire logic [alr_pkg::COLOR_W-1:0]   blue,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic signed [CW+1:0]               pixel_x,
   output logic signed [CW+1:0]               pixel_y,
   output logic [alr_pkg::COLOR_W-1:0]        pixel_red,
   output logic [alr_pkg::COLOR_W-1:0]        pixel_green,
   output logic [alr_pkg::COLOR_W-1:0]        pixel_blue,
   output logic                               last
);
   import alr_pkg::*;

   localparam int PW = CW + 8;
   localparam int OW = CW + 2;

   logic                              active_ff, active_in;
   logic                              x_major_ff, x_major_in;
   logic                              x_neg_ff, x_neg_in;
   logic                              y_neg_ff, y_neg_in;
   logic [CW-1:0]                     cur_x_ff, cur_x_in;
   logic [CW-1:0]                     cur_y_ff, cur_y_in;
   logic [CW-1:0]                     stop_x_ff, stop_x_in;
   logic [CW-1:0]                     stop_y_ff, stop_y_in;
   logic [CW:0]                       err_ff, err_in;
   logic [CW:0]                       major_ff, major_in;
   logic [CW:0]                       minor_ff, minor_in;
   logic [LANES-1:0][COLOR_W-1:0]     color_ff, color_in;

   logic                              out_valid_ff, out_valid_in;
   logic [OW-1:0]                     out_x_ff, out_x_in;
   logic [OW-1:0]                     out_y_ff, out_y_in;
   logic [LANES-1:0][COLOR_W-1:0]     out_c_ff, out_c_in;
   logic                              out_last_ff, out_last_in;

   logic [CW:0]                       dx, dy, dx_neg, dy_neg, err_neg;
   logic [CW-1:0]                     adx, ady, ae;
   logic [LANES-1:0][PW-1:0]          prod;
   logic                              div_done;
   logic [LANES-1:0][QUOT_W-1:0]      quot;
   logic [LANES-1:0]                  rem_nz;
   logic [CW+2:0]                     err_sum, err_wrap;
   logic                              minor_step;
   logic                              nbr_pos;
   logic [OW-1:0]                     cur_x_ext, cur_y_ext, nbr_x, nbr_y;
   logic [CW-1:0]                     x_stepped, y_stepped;

   always_comb begin
      dx     = {1'b0, x_end} - {1'b0, x_start};
      dy     = {1'b0, y_end} - {1'b0, y_start};
      dx_neg = -dx;
      dy_neg = -dy;
      adx    = dx[CW] ? dx_neg[CW-1:0] : dx[CW-1:0];
      ady    = dy[CW] ? dy_neg[CW-1:0] : dy[CW-1:0];

      err_neg = -err_ff;
      ae      = err_ff[CW] ? err_neg[CW-1:0] : err_ff[CW-1:0];
      for (int i = 0; i < LANES; i++) begin
         prod[i] = PW'(COLOR_MAX - color_ff[i]) * PW'(ae);
      end

      err_sum    = {{2{err_ff[CW]}}, err_ff} + {2'b00, minor_ff};
      minor_step = $signed(err_sum) >= $signed({3'b000, major_ff[CW:1]});
      err_wrap   = err_sum - {2'b00, major_ff};

      x_stepped = x_neg_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
      y_stepped = y_neg_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;

      nbr_pos   = (!err_ff[CW] && err_ff != '0) ^ (x_major_ff ? y_neg_ff : x_neg_ff);
      cur_x_ext = {2'b00, cur_x_ff};
      cur_y_ext = {2'b00, cur_y_ff};
      nbr_x     = cur_x_ext;
      nbr_y     = cur_y_ext;
      if (x_major_ff) begin
         nbr_y = nbr_pos ? cur_y_ext + 1'b1 : cur_y_ext - 1'b1;
      end else begin
         nbr_x = nbr_pos ? cur_x_ext + 1'b1 : cur_x_ext - 1'b1;
      end
   end

   alr_divider #(.CW(CW)) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .divisor  (major_ff),
      .dividend (prod),
      .done     (div_done),
      .quot     (quot),
      .rem_nz   (rem_nz)
   );

   always_comb begin
      active_in  = active_ff;
      x_major_in = x_major_ff;
      x_neg_in   = x_neg_ff;
      y_neg_in   = y_neg_ff;
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      stop_x_in  = stop_x_ff;
      stop_y_in  = stop_y_ff;
      err_in     = err_ff;
      major_in   = major_ff;
      minor_in   = minor_ff;
      color_in   = color_ff;

      if (cmd.load_line) begin
         x_major_in = adx > ady;
         x_neg_in   = x_end <= x_start;
         y_neg_in   = y_end <= y_start;
         major_in   = (adx > ady) ? {adx, 1'b0} : {ady, 1'b0};
         minor_in   = (adx > ady) ? {ady, 1'b0} : {adx, 1'b0};
         err_in     = '0;
         cur_x_in   = x_start;
         cur_y_in   = y_start;
         stop_x_in  = x_end;
         stop_y_in  = y_end;
         color_in   = {red, green, blue};
         active_in  = (adx != '0) || (ady != '0);
      end else if (cmd.advance) begin
         err_in = minor_step ? err_wrap[CW:0] : err_sum[CW:0];
         if (x_major_ff) begin
            cur_x_in = x_stepped;
            if (minor_step) begin
               cur_y_in = y_stepped;
            end
         end else begin
            cur_y_in = y_stepped;
            if (minor_step) begin
               cur_x_in = x_stepped;
            end
         end
      end else if (cmd.end_line) begin
         active_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_c_in     = out_c_ff;
      out_last_in  = out_last_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
         case (cmd.out_sel)
            PIX_MAIN: begin
               out_x_in    = cur_x_ext;
               out_y_in    = cur_y_ext;
               out_last_in = 1'b0;
               for (int i = 0; i < LANES; i++) begin
                  out_c_in[i] = color_ff[i] + quot[i] + COLOR_W'(rem_nz[i]);
               end
            end
            PIX_NBR: begin
               out_x_in    = nbr_x;
               out_y_in    = nbr_y;
               out_last_in = 1'b0;
               for (int i = 0; i < LANES; i++) begin
                  out_c_in[i] = COLOR_MAX - quot[i];
               end
            end
            PIX_END: begin
               out_x_in    = {2'b00, stop_x_ff};
               out_y_in    = {2'b00, stop_y_ff};
               out_last_in = 1'b1;
               out_c_in    = color_ff;
            end
            default: begin
               out_valid_in = out_valid_ff && !rsp_ready;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
      x_major_ff  <= x_major_in;
      x_neg_ff    <= x_neg_in;
      y_neg_ff    <= y_neg_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      stop_x_ff   <= stop_x_in;
      stop_y_ff   <= stop_y_in;
      err_ff      <= err_in;
      major_ff    <= major_in;
      minor_ff    <= minor_in;
      color_ff    <= color_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_c_ff    <= out_c_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      status.line_active = active_ff;
      status.div_done    = div_done;
      status.out_free    = !out_valid_ff || rsp_ready;
      status.at_stop     = x_major_ff ? (cur_x_ff == stop_x_ff) : (cur_y_ff == stop_y_ff);
      rsp_valid   = out_valid_ff;
      pixel_x     = $signed(out_x_ff);
      pixel_y     = $signed(out_y_ff);
      pixel_red   = out_c_ff[2];
      pixel_green = out_c_ff[1];
      pixel_blue  = out_c_ff[0];
      last        = out_last_ff;
   end

endmodule

`default_nettype wire

>>> rtl/alr_control.sv
`default_nettype none

module alr_control (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_op,
   output logic                      req_ready,
   input  wire alr_pkg::status_type  status,
   output alr_pkg::cmd_type          cmd
);
   import alr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_MAIN,
      S_NBR,
      S_END
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.out_sel = PIX_MAIN;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_op == OP_START) begin
                  cmd.load_line = 1'b1;
                  state_in      = S_END;
               end else if (status.line_active) begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_MAIN;
            end
         end
         S_MAIN: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = PIX_MAIN;
               state_in     = S_NBR;
            end
         end
         S_NBR: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = PIX_NBR;
               cmd.advance  = 1'b1;
               state_in     = S_END;
            end
         end
         S_END: begin
            if (!status.at_stop) begin
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = PIX_END;
               cmd.end_line = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/antialiased_line_rasterizer.sv
// channel   dir  handshake          payload
// req_chan  in   valid/ready beat   op, x_start, y_start, x_end, y_end, red, green, blue
// rsp_chan  out  valid/ready beat   pixel_x, pixel_y, pixel_red/green/blue, last
//
// A start beat loads the line in idle; a single-point start then loads its pixel into the
// output register in the end state.
// A step beat is accepted in idle, runs the three-lane shift-subtract divider that forms
// the blend weights (8 iterations), then emits the main and neighbour pixels and, at the
// stop, the end pixel. A step with no active line is ignored.
// Reset is synchronous; it clears the sequencer, the line-active flag and output valid.
// A stalled rsp_chan holds the sequencer in its emit states; req_ready is high only in idle.
`default_nettype none

module antialiased_line_rasterizer #(
   parameter int COORD_WIDTH = 11
) (
   input  wire logic  clock,
   input  wire logic  reset,
   alr_req_if.sink    req_chan,
   alr_rsp_if.source  rsp_chan
);
   import alr_pkg::*;

   cmd_type    cmd;
   status_type status;

   alr_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   alr_datapath #(.CW(COORD_WIDTH)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .x_start     (req_chan.x_start),
      .y_start     (req_chan.y_start),
      .x_end       (req_chan.x_end),
      .y_end       (req_chan.y_end),
      .red         (req_chan.red),
      .green       (req_chan.green),
      .blue        (req_chan.blue),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .pixel_x     (rsp_chan.pixel_x),
      .pixel_y     (rsp_chan.pixel_y),
      .pixel_red   (rsp_chan.pixel_red),
      .pixel_green (rsp_chan.pixel_green),
      .pixel_blue  (rsp_chan.pixel_blue),
      .last        (rsp_chan.last)
   );

endmodule

`default_nettype wire
